### rtl/xcfd_pkg.sv
// Package for the frame deframer: constants, FSM state type and register indexes.
// No dependencies.
package xcfd_pkg;

   localparam int unsigned MIN_HELD   = 5;    // sync, sync, x, len, check
   localparam int unsigned HDR_LEN    = 4;
   localparam int unsigned LEN_OFFSET = 3;    // length byte within the header

   localparam logic [0:0] CSR_SYNC_FIRST  = 1'b0;
   localparam logic [0:0] CSR_SYNC_SECOND = 1'b1;
   localparam logic [7:0] SYNC_FIRST_RST  = 8'hAA;
   localparam logic [7:0] SYNC_SECOND_RST = 8'h55;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WRITE,
      ST_CHECK,
      ST_SYNC0,
      ST_SYNC1,
      ST_LEN,
      ST_XOR,
      ST_GATHER,
      ST_OUT
   } state_type;

endpackage

### rtl/xcfd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module xcfd_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

### rtl/xor_checked_frame_deframer_top.sv
// Top level of the sync-header, length-framed deframer with XOR check.
// Depends on xcfd_pkg and xcfd_ram.
//
// Usage:
//  - req_ channel: one received byte per transfer (req_valid / req_stall).
//  - rsp_ channel: frame words of up to 8 bytes, first byte in bits 7:0,
//    unused lanes zero, with byte count and a last mark (rsp_valid / rsp_stall).
//  - csr_ channel: writes sync_first (index 0) or sync_second (index 1)
//    with csr_valid / csr_ready.
// Each byte goes into a circular byte store held in one RAM. After the
// write, a sequencer scans from the oldest byte through the RAM read port:
// a sync miss drops one byte, a complete frame is XOR checked byte by byte,
// and a passing frame is read out word by word and then removed.
// Steps: a byte is accepted, written and checked while fewer than 5 are
// held; while a header waits for the rest of its frame, its sync and
// length bytes are read again for each new byte. Each word is gathered
// byte by byte and then held on rsp_ while rsp_stall is high.
// req_stall stays high until the sequencer is idle again, so rsp_stall backs
// up into req_. Reset clears pointers and count, restores sync defaults and
// holds req_stall high; the RAM is not cleared: only held bytes are read.
module xor_checked_frame_deframer_top #(
   parameter int unsigned STORE_DEPTH = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_frame_word,
   output logic [3:0]  rsp_byte_count,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   localparam int unsigned AW = $clog2(STORE_DEPTH);
   localparam int unsigned CW = $clog2(STORE_DEPTH + 1);

   xcfd_pkg::state_type state_ff, state_in;

   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] held_ff, held_in;
   logic [7:0]    sync_first_ff, sync_second_ff;
   logic [7:0]    byte_ff, byte_in;       // accepted input byte
   logic [8:0]    total_ff, total_in;     // frame length in bytes
   logic [8:0]    idx_ff, idx_in;         // next byte offset to read
   logic [7:0]    xacc_ff, xacc_in;
   logic [3:0]    lane_ff, lane_in;       // lane within output word
   logic [63:0]   word_ff, word_in;
   logic [3:0]    cnt_ff, cnt_in;
   logic          last_ff, last_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [7:0]    rd_data;
   logic [8:0]    rd_off;
   logic [8:0]    len_total;
   logic          sync0_ok, sync1_ok, frame_held, check_ok, frame_end, word_done;

   // circular add: both operands are below the depth
   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                              input logic [AW:0]   off);
      logic [AW:0] sum;
      sum = {1'b0, base} + off;
      if (sum >= (AW+1)'(STORE_DEPTH)) sum = sum - (AW+1)'(STORE_DEPTH);
      return sum[AW-1:0];
   endfunction

   xcfd_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (byte_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign csr_ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff  <= xcfd_pkg::SYNC_FIRST_RST;
         sync_second_ff <= xcfd_pkg::SYNC_SECOND_RST;
      end else if (csr_valid) begin
         case (csr_index)
            xcfd_pkg::CSR_SYNC_FIRST:  sync_first_ff  <= csr_wdata;
            xcfd_pkg::CSR_SYNC_SECOND: sync_second_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // write position: held count stays below the depth, so no full drop
   assign wr_addr = wrap_add(head_ff, (AW+1)'(held_ff));
   assign wr_en   = (state_ff == xcfd_pkg::ST_WRITE);
   assign rd_addr = wrap_add(head_ff, (AW+1)'(rd_off));

   // rd_data always holds the byte addressed in the previous cycle
   assign sync0_ok   = (rd_data == sync_first_ff);
   assign sync1_ok   = (rd_data == sync_second_ff);
   assign len_total  = 9'(xcfd_pkg::MIN_HELD) + {1'b0, rd_data};
   assign frame_held = (held_ff >= CW'(len_total));
   assign check_ok   = (xacc_ff == rd_data);
   assign frame_end  = (idx_ff == total_ff);
   assign word_done  = (lane_ff == 4'd7) || frame_end;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         xcfd_pkg::ST_IDLE:
            if (req_valid) state_in = xcfd_pkg::ST_WRITE;
         xcfd_pkg::ST_WRITE:  state_in = xcfd_pkg::ST_CHECK;
         xcfd_pkg::ST_CHECK:
            if (held_ff >= CW'(xcfd_pkg::MIN_HELD)) state_in = xcfd_pkg::ST_SYNC0;
            else state_in = xcfd_pkg::ST_IDLE;
         xcfd_pkg::ST_SYNC0:
            if (sync0_ok) state_in = xcfd_pkg::ST_SYNC1;
            else state_in = xcfd_pkg::ST_CHECK;
         xcfd_pkg::ST_SYNC1:
            if (sync1_ok) state_in = xcfd_pkg::ST_LEN;
            else state_in = xcfd_pkg::ST_CHECK;
         xcfd_pkg::ST_LEN:
            if (frame_held) state_in = xcfd_pkg::ST_XOR;
            else state_in = xcfd_pkg::ST_IDLE;
         xcfd_pkg::ST_XOR:
            if (frame_end) begin
               if (check_ok) state_in = xcfd_pkg::ST_GATHER;
               else state_in = xcfd_pkg::ST_CHECK;
            end
         xcfd_pkg::ST_GATHER:
            if (word_done) state_in = xcfd_pkg::ST_OUT;
         xcfd_pkg::ST_OUT:
            if (!rsp_stall) begin
               if (last_ff) state_in = xcfd_pkg::ST_IDLE;
               else state_in = xcfd_pkg::ST_GATHER;
            end
         default: state_in = xcfd_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      head_in  = head_ff;
      held_in  = held_ff;
      byte_in  = byte_ff;
      total_in = total_ff;
      idx_in   = idx_ff;
      xacc_in  = xacc_ff;
      lane_in  = lane_ff;
      word_in  = word_ff;
      cnt_in   = cnt_ff;
      last_in  = last_ff;
      rd_off   = idx_ff;
      req_stall = reset || (state_ff != xcfd_pkg::ST_IDLE);
      rsp_valid = !reset && (state_ff == xcfd_pkg::ST_OUT);
      case (state_ff)
         xcfd_pkg::ST_IDLE:
            if (req_valid) byte_in = req_rx_byte;
         xcfd_pkg::ST_WRITE: held_in = held_ff + CW'(1);
         xcfd_pkg::ST_CHECK: rd_off = 9'd0;
         xcfd_pkg::ST_SYNC0: begin
            rd_off = 9'd1;
            if (!sync0_ok) begin
               head_in = wrap_add(head_ff, (AW+1)'(1));
               held_in = held_ff - CW'(1);
            end
         end
         xcfd_pkg::ST_SYNC1: begin
            rd_off = 9'(xcfd_pkg::LEN_OFFSET);
            if (!sync1_ok) begin
               head_in = wrap_add(head_ff, (AW+1)'(1));
               held_in = held_ff - CW'(1);
            end
         end
         xcfd_pkg::ST_LEN: begin
            // start the XOR pass at offset 0
            rd_off   = 9'd0;
            total_in = len_total;
            idx_in   = 9'd1;
            xacc_in  = 8'd0;
         end
         xcfd_pkg::ST_XOR: begin
            if (frame_end) begin
               // rd_data is the check byte; prepare readout from offset 0
               rd_off  = 9'd0;
               idx_in  = 9'd1;
               lane_in = 4'd0;
               word_in = 64'd0;
               if (!check_ok) begin
                  head_in = wrap_add(head_ff, (AW+1)'(1));
                  held_in = held_ff - CW'(1);
               end
            end else begin
               xacc_in = xacc_ff ^ rd_data;
               idx_in  = idx_ff + 9'd1;
            end
         end
         xcfd_pkg::ST_GATHER: begin
            word_in = word_ff | (64'(rd_data) << {lane_ff[2:0], 3'b000});
            if (word_done) begin
               cnt_in  = lane_ff + 4'd1;
               last_in = frame_end;
            end else begin
               lane_in = lane_ff + 4'd1;
               idx_in  = idx_ff + 9'd1;
            end
         end
         xcfd_pkg::ST_OUT:
            if (!rsp_stall) begin
               if (last_ff) begin
                  head_in = wrap_add(head_ff, (AW+1)'(total_ff));
                  held_in = held_ff - CW'(total_ff);
               end else begin
                  // next word: offset idx_ff is being read now
                  lane_in = 4'd0;
                  word_in = 64'd0;
                  idx_in  = idx_ff + 9'd1;
               end
            end
         default: ;
      endcase
   end

   assign rsp_frame_word = word_ff;
   assign rsp_byte_count = cnt_ff;
   assign rsp_last       = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= xcfd_pkg::ST_IDLE;
         head_ff  <= '0;
         held_ff  <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         held_ff  <= held_in;
      end
      byte_ff  <= byte_in;
      total_ff <= total_in;
      idx_ff   <= idx_in;
      xacc_ff  <= xacc_in;
      lane_ff  <= lane_in;
      word_ff  <= word_in;
      cnt_ff   <= cnt_in;
      last_ff  <= last_in;
   end

endmodule

### bench/tb_xor_checked_frame_deframer_top.sv
// Testbench for the sync-header XOR-checked frame deframer.
// Depends on xcfd_pkg and xor_checked_frame_deframer_top; self-checking against
// a built-in frame parser model.
module tb_xor_checked_frame_deframer_top;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [63:0] word;
      logic [3:0]  count;
      logic        last;
   } frame_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_frame_word;
   logic [3:0]  rsp_byte_count;
   logic        rsp_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [0:0]  csr_index = '0;
   logic [7:0]  csr_wdata = '0;

   xor_checked_frame_deframer_top u_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Model state: receive store, sync bytes.
   logic [7:0]  rx_bytes[$];
   logic [7:0]  sync_a = xcfd_pkg::SYNC_FIRST_RST;
   logic [7:0]  sync_b = xcfd_pkg::SYNC_SECOND_RST;

   frame_word_type expected_words[$];
   logic [7:0]  pending_bytes[$];
   int          mismatches = 0;
   int          frames_seen = 0;
   int          bytes_sent = 0;
   bit          long_hold_go = 1'b0;   // starts the long receiver hold-off
   bit          hold_active = 1'b0;

   // Append one byte, scan, and queue the words of at most one frame.
   task automatic parse_byte(input logic [7:0] b);
      int             total;
      logic [7:0]     x;
      frame_word_type fw;
      rx_bytes.insert(rx_bytes.size(), b);
      while (rx_bytes.size() >= xcfd_pkg::MIN_HELD) begin
         if (rx_bytes[0] != sync_a || rx_bytes[1] != sync_b) begin
            void'(rx_bytes.pop_front());
            continue;
         end
         total = xcfd_pkg::HDR_LEN + 1 + rx_bytes[3];
         if (rx_bytes.size() < total) return;
         x = '0;
         for (int i = 0; i < total - 1; i++) x ^= rx_bytes[i];
         if (x != rx_bytes[total-1]) begin
            void'(rx_bytes.pop_front());
            continue;
         end
         for (int i = 0; i < total; i += 8) begin
            fw = '0;
            fw.count = (total - i > 8) ? 4'd8 : 4'(total - i);
            for (int k = 0; k < fw.count; k++) fw.word[8*k +: 8] = rx_bytes[i+k];
            fw.last = (i + 8 >= total);
            expected_words.insert(expected_words.size(), fw);
         end
         for (int i = 0; i < total; i++) void'(rx_bytes.pop_front());
         return;
      end
   endtask

   task automatic add_byte(input logic [7:0] b);
      pending_bytes.insert(pending_bytes.size(), b);
   endtask

   // Queue a well-formed frame, optionally with a corrupted check byte.
   task automatic push_frame(input int len, input bit corrupt);
      logic [7:0] x, v;
      x = sync_a ^ sync_b;
      add_byte(sync_a);
      add_byte(sync_b);
      v = 8'($urandom); add_byte(v); x ^= v;
      add_byte(8'(len)); x ^= 8'(len);
      for (int i = 0; i < len; i++) begin
         v = 8'($urandom); add_byte(v); x ^= v;
      end
      add_byte(corrupt ? ~x : x);
   endtask

   // Driver: one transfer per byte, random gap before each.
   int send_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            parse_byte(req_rx_byte);
            bytes_sent++;
            req_valid <= 1'b0;
            send_gap = $urandom_range(3) == 0 ? 0 : $urandom_range(15);
         end else if (!req_valid) begin
            if (send_gap > 0) send_gap--;
            else if (pending_bytes.size() > 0) begin
               req_rx_byte <= pending_bytes.pop_front();
               req_valid <= 1'b1;
            end
         end
      end
   end

   // Long receiver hold-off, counted in cycles.
   initial begin
      wait (long_hold_go);
      hold_active = 1'b1;
      repeat (6000) @(posedge clock);
      hold_active = 1'b0;
   end

   // Receiver stall: per-word random wait, plus the long hold-off.
   int rsp_wait = 0;
   always @(posedge clock) begin
      if (hold_active) begin
         rsp_stall <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
         rsp_wait = $urandom_range(1) ? 0 : $urandom_range(15);
         rsp_stall <= (rsp_wait > 0);
      end else if (rsp_wait > 0) begin
         rsp_wait--;
         rsp_stall <= (rsp_wait > 0);
      end else rsp_stall <= 1'b0;
   end

   // Monitor: compare each accepted word with the oldest expectation.
   always @(posedge clock) begin
      frame_word_type exp_w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected word %h count %0d last %0d",
                        rsp_frame_word, rsp_byte_count, rsp_last);
         end else begin
            exp_w = expected_words.pop_front();
            if (exp_w.word !== rsp_frame_word || exp_w.count !== rsp_byte_count
                || exp_w.last !== rsp_last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("word mismatch: exp %h/%0d/%0d got %h/%0d/%0d",
                           exp_w.word, exp_w.count, exp_w.last,
                           rsp_frame_word, rsp_byte_count, rsp_last);
            end
            if (exp_w.last) frames_seen++;
         end
      end
   end

   // Register write, only while idle.
   task automatic write_sync(input logic [0:0] idx, input logic [7:0] val);
      @(posedge clock);
      csr_index <= idx;
      csr_wdata <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == xcfd_pkg::CSR_SYNC_FIRST) sync_a = val; else sync_b = val;
   endtask

   // Wait until every byte is sent, every word seen and the block is idle.
   task automatic drain();
      while (pending_bytes.size() > 0 || req_valid || expected_words.size() > 0
             || req_stall)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Random traffic: mostly good frames, some bad checks and noise.
   task automatic random_phase(input int n);
      int r;
      for (int f = 0; f < n; f++) begin
         r = $urandom_range(9);
         if (r < 6) push_frame($urandom_range(4) == 0 ? $urandom_range(40)
                               : $urandom_range(12), 1'b0);
         else if (r < 8) push_frame($urandom_range(12), 1'b1);
         else repeat ($urandom_range(1, 6)) add_byte(8'($urandom));
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      // Directed: empty payload, noise before a header, bad check, one full word.
      push_frame(0, 1'b0);
      add_byte(8'h00);
      add_byte(8'hFF);
      push_frame(4, 1'b1);
      push_frame(3, 1'b0);
      drain();
      // Long receiver hold-off while a max-length frame and more arrive.
      long_hold_go = 1'b1;
      push_frame(255, 1'b0);
      push_frame(1, 1'b0);
      drain();
      write_sync(xcfd_pkg::CSR_SYNC_FIRST, 8'h00);
      write_sync(xcfd_pkg::CSR_SYNC_SECOND, 8'hFF);
      push_frame(2, 1'b0);
      drain();
      write_sync(xcfd_pkg::CSR_SYNC_FIRST, 8'hFF);
      write_sync(xcfd_pkg::CSR_SYNC_SECOND, 8'h00);
      random_phase(1);
      drain();
      write_sync(xcfd_pkg::CSR_SYNC_FIRST, 8'h5A);
      write_sync(xcfd_pkg::CSR_SYNC_SECOND, 8'h5A);
      random_phase(1);
      drain();
      write_sync(xcfd_pkg::CSR_SYNC_FIRST, xcfd_pkg::SYNC_FIRST_RST);
      write_sync(xcfd_pkg::CSR_SYNC_SECOND, xcfd_pkg::SYNC_SECOND_RST);
      random_phase(2);
      drain();
      $display("sent %0d bytes, %0d frames checked, sync settings incl. 00/FF",
               bytes_sent, frames_seen);
      if (mismatches == 0) $display("xor_checked_frame_deframer_top: match");
      else $display("xor_checked_frame_deframer_top: mismatch");
      $finish;
   end

   initial begin
      #20ms;
      $display("xor_checked_frame_deframer_top: mismatch");
      $finish;
   end
endmodule
